// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Opcodes, status codes and the controller/datapath handshake types shared by
// the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int WORD_BITS = 32;
   localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

   typedef logic [1:0] bba_op_type;
   localparam bba_op_type OP_ALLOC       = 2'd0;
   localparam bba_op_type OP_FREE_BLOCK  = 2'd1;
   localparam bba_op_type OP_FREE_RANGE  = 2'd2;
   localparam bba_op_type OP_RESERVE     = 2'd3;

   typedef logic [1:0] bba_status_type;
   localparam bba_status_type ST_OK        = 2'd0;
   localparam bba_status_type ST_NO_FREE   = 2'd1;
   localparam bba_status_type ST_RANGE     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request beat
      logic prep1;    // end block, clamp, range status
      logic prep2;    // first/last word and bit bounds
      logic zero;     // set up the block 0 mark after a range free
      logic rd;       // read current bitmap word
      logic modify;   // write modified word, update count, step word
      logic no_free;  // allocate with nothing free
      logic emit;     // load result register
      logic sweep;    // post-reset fill of the bitmap
   } bba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      bba_op_type op;
      logic       free_zero;
      logic       empty;
      logic       word_last;
      logic       alloc_hit;
      logic       sweep_last;
      logic       rsp_free;
   } bba_sts_type;

endpackage

`default_nettype wire

// ===== hdl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba channel interfaces
// Request and response channels of the bitmap block allocator, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] address;
   logic [31:0] length_bytes;

   modport source (output valid, output op, output address, output length_bytes,
                   input ready);
   modport sink   (input valid, input op, input address, input length_bytes,
                   output ready);
endinterface

interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [26:0] block_address;
   logic [17:0] free_kib;

   modport source (output valid, output status, output block_address,
                   output free_kib, input ready);
   modport sink   (input valid, input status, input block_address,
                   input free_kib, output ready);
endinterface

`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Block allocator over a used/free bitmap: allocate lowest free block, free
// one block, free or reserve a byte range; every request returns status and
// free memory in KiB.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  req_chan  in    op, address, length_bytes
//  rsp_chan  out   status, block_address, free_kib
//
//  After reset the bitmap is filled with ones, one word per cycle, with
//  req_chan.ready low until the last word is written.
//  Every bitmap word visited costs a read, then a write back, on the
//  single memory port. Allocate visits the words from word 0 up to the one
//  that holds the lowest free block, and reads none when nothing is free.
//  Range ops and single frees visit each word touched, plus the block 0
//  mark after a range free. One request is in flight at a time; a finished
//  response waits in its output register and the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS  = 32768,
   parameter int BLOCK_BYTES = 4096
) (
   input  wire         clock,
   input  wire         reset,
   bba_req_if.sink     req_chan,
   bba_rsp_if.source   rsp_chan
);
   import bba_pkg::*;

   bba_cmd_type cmd;
   bba_sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_chan.op),
      .req_address       (req_chan.address),
      .req_length_bytes  (req_chan.length_bytes),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_block_address (rsp_chan.block_address),
      .rsp_free_kib      (rsp_chan.free_kib)
   );

endmodule

`default_nettype wire

// ===== hdl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap memory, word read-modify-write unit, free block counter and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath #(
   parameter int MAX_BLOCKS  = 32768,
   parameter int BLOCK_BYTES = 4096
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire bba_pkg::bba_cmd_type cmd,
   output bba_pkg::bba_sts_type   sts,
   input  wire [1:0]              req_op,
   input  wire [31:0]             req_address,
   input  wire [31:0]             req_length_bytes,
   input  wire                    rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [26:0]            rsp_block_address,
   output logic [17:0]            rsp_free_kib
);
   import bba_pkg::*;

   localparam int SHIFT     = $clog2(BLOCK_BYTES);
   localparam int AW        = 32 - SHIFT;
   localparam int FW        = $clog2(MAX_BLOCKS + 1);
   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

   bba_op_type      op_ff, op_in;
   logic [AW-1:0]   start_blk_ff, start_blk_in;
   logic [AW-1:0]   count_blk_ff, count_blk_in;
   logic [FW-1:0]   end_blk_ff, end_blk_in;
   logic [WW-1:0]   cur_word_ff, cur_word_in;
   logic [WW-1:0]   last_word_ff, last_word_in;
   logic            first_ff, first_in;
   logic [4:0]      lo_ff, lo_in;
   logic [4:0]      hi_ff, hi_in;
   bba_status_type  status_ff, status_in;
   logic [26:0]     baddr_ff, baddr_in;
   logic [FW-1:0]   free_ff, free_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   bba_status_type  rsp_status_ff, rsp_status_in;
   logic [26:0]     rsp_baddr_ff, rsp_baddr_in;
   logic [17:0]     rsp_kib_ff, rsp_kib_in;

   logic [32:0]     end_sum;
   logic            over;
   logic [31:0]     start32, last32, blk32, kib32;
   logic [63:0]     byte_addr;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, range_mask, alloc_mask, mask, new_word;
   logic [5:0]      changed;
   logic [4:0]      alloc_bit;
   logic            marking;
   logic            mem_we;
   logic [WORD_BITS-1:0] mem_wdata;

   always_comb begin
      end_sum = 33'(start_blk_ff) + 33'(count_blk_ff);
      over    = end_sum > 33'(MAX_BLOCKS);
      start32 = 32'(start_blk_ff);
      last32  = 32'(end_blk_ff) - 32'd1;
   end

   // word masks: range bounds, or lowest clear bit for allocation
   always_comb begin
      lo_mask    = first_ff ? (WORD_ONES << lo_ff) : WORD_ONES;
      hi_mask    = (cur_word_ff == last_word_ff) ? (WORD_ONES >> (5'd31 - hi_ff))
                                                 : WORD_ONES;
      range_mask = lo_mask & hi_mask;
      alloc_mask = ~rd_data_ff & (rd_data_ff + 32'd1);
      alloc_bit  = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (alloc_mask[i]) alloc_bit = alloc_bit | 5'(i);
      end
      marking  = (op_ff == OP_ALLOC) || (op_ff == OP_RESERVE);
      mask     = (op_ff == OP_ALLOC) ? alloc_mask : range_mask;
      new_word = marking ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
      changed  = 6'($countones(new_word ^ rd_data_ff));
      blk32    = (32'(cur_word_ff) << 5) | 32'(alloc_bit);
      byte_addr = 64'(blk32) << SHIFT;
      kib32    = 32'(free_ff) << 2;
   end

   always_comb begin
      op_in        = op_ff;
      start_blk_in = start_blk_ff;
      count_blk_in = count_blk_ff;
      end_blk_in   = end_blk_ff;
      cur_word_in  = cur_word_ff;
      last_word_in = last_word_ff;
      first_in     = first_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      status_in    = status_ff;
      baddr_in     = baddr_ff;
      free_in      = free_ff;

      if (cmd.load) begin
         op_in        = req_op;
         start_blk_in = AW'(req_address >> SHIFT);
         count_blk_in = (req_op == OP_FREE_BLOCK) ? AW'(1) : AW'(req_length_bytes >> SHIFT);
         cur_word_in  = '0;
         last_word_in = WW'(MAP_WORDS - 1);
         first_in     = 1'b1;
         lo_in        = '0;
         hi_in        = 5'd31;
         status_in    = ST_OK;
         baddr_in     = '0;
      end
      if (cmd.prep1) begin
         end_blk_in = over ? FW'(MAX_BLOCKS) : end_sum[FW-1:0];
         status_in  = (over && (count_blk_ff != '0)) ? ST_RANGE : ST_OK;
      end
      if (cmd.prep2) begin
         cur_word_in  = start32[WW+4:5];
         last_word_in = last32[WW+4:5];
         first_in     = 1'b1;
         lo_in        = start32[4:0];
         hi_in        = last32[4:0];
      end
      if (cmd.no_free) status_in = ST_NO_FREE;
      if (cmd.modify) begin
         cur_word_in = cur_word_ff + WW'(1);
         first_in    = 1'b0;
         free_in     = marking ? (free_ff - FW'(changed)) : (free_ff + FW'(changed));
         if ((op_ff == OP_ALLOC) && (rd_data_ff != WORD_ONES)) begin
            baddr_in = byte_addr[26:0];
         end
      end
      // block 0 is forced used after a range free; overrides the word step
      if (cmd.zero) begin
         op_in        = OP_RESERVE;
         cur_word_in  = '0;
         last_word_in = '0;
         first_in     = 1'b1;
         lo_in        = '0;
         hi_in        = '0;
      end
      if (cmd.sweep) cur_word_in = cur_word_ff + WW'(1);
   end

   always_comb begin
      mem_we    = cmd.sweep || cmd.modify;
      mem_wdata = cmd.sweep ? WORD_ONES : new_word;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_baddr_in  = rsp_baddr_ff;
      rsp_kib_in    = rsp_kib_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_baddr_in  = baddr_ff;
         rsp_kib_in    = kib32[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[cur_word_ff] <= mem_wdata;
      if (cmd.rd) rd_data_ff <= map_mem[cur_word_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_word_ff  <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_word_ff  <= cur_word_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_blk_ff  <= start_blk_in;
      count_blk_ff  <= count_blk_in;
      end_blk_ff    <= end_blk_in;
      last_word_ff  <= last_word_in;
      first_ff      <= first_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      status_ff     <= status_in;
      baddr_ff      <= baddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_baddr_ff  <= rsp_baddr_in;
      rsp_kib_ff    <= rsp_kib_in;
   end

   always_comb begin
      sts.op         = op_ff;
      sts.free_zero  = (free_ff == '0);
      sts.empty      = (33'(start_blk_ff) >= 33'(end_blk_ff));
      sts.word_last  = (cur_word_ff == last_word_ff);
      sts.alloc_hit  = (rd_data_ff != WORD_ONES);
      sts.sweep_last = (cur_word_ff == WW'(MAP_WORDS - 1));
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_baddr_ff;
   assign rsp_free_kib      = rsp_kib_ff;

endmodule

`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: post-reset fill, request decode, per-word
// read-modify-write walk, block 0 fix-up and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire bba_pkg::bba_sts_type sts,
   output bba_pkg::bba_cmd_type   cmd
);
   import bba_pkg::*;

   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_PREP1  = 3'd3;
   localparam logic [2:0] S_PREP2  = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_MODIFY = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       zero_step;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      zero_step = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == OP_ALLOC) begin
               if (sts.free_zero) begin
                  cmd.no_free = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = S_PREP2;
         end
         S_PREP2: begin
            cmd.prep2 = 1'b1;
            if (!sts.empty) begin
               state_in = S_READ;
            end else if (sts.op == OP_FREE_RANGE) begin
               zero_step = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            cmd.modify = 1'b1;
            if (sts.op == OP_ALLOC) begin
               state_in = (sts.alloc_hit || sts.word_last) ? S_DONE : S_READ;
            end else if (!sts.word_last) begin
               state_in = S_READ;
            end else if (sts.op == OP_FREE_RANGE) begin
               zero_step = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // range free finishes with a mark of block 0, run as a one-bit reserve
      if (zero_step) begin
         cmd.zero = 1'b1;
         state_in = S_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire
